FILE: hw/rtl/decimal_long_division_by_small_int_assert.svh
// Assertion macros used by the port-level checker of the decimal divider.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef DECIMAL_LONG_DIVISION_BY_SMALL_INT_ASSERT_SVH
`define DECIMAL_LONG_DIVISION_BY_SMALL_INT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DLD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("decimal divider assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decimal divider assertion failed");

`endif

FILE: hw/rtl/dld_pkg.sv
// Package for the decimal long divider: widths, limits and the
// controller/datapath command and status types. No dependencies.
package dld_pkg;

  // Fixed field widths of the channels.
  localparam int DIGIT_W = 4;
  localparam int CFG_W   = 16;
  localparam int REM_W   = 16;

  // Divider sizing and the fraction limit.
  localparam int DIVISOR_BITS        = 16;
  localparam int MAX_FRACTION_DIGITS = 63;
  localparam int FRAC_CNT_W = (MAX_FRACTION_DIGITS < 2) ? 1 :
                              $clog2(MAX_FRACTION_DIGITS + 1);
  localparam bit NO_FRACTION = (MAX_FRACTION_DIGITS == 0);

  // Remainder times ten plus a digit needs four extra bits.
  localparam int PROD_W = DIVISOR_BITS + 4;

  // One restoring step per quotient bit; quotient digits stay below ten.
  localparam int QSTEPS = 4;
  localparam int STEP_W = 2;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(9);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              step;
    logic [STEP_W-1:0] step_idx;
    logic              emit;
  } dld_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_zero;
    logic out_free;
    logic cont;
  } dld_sts_t;

endpackage

FILE: hw/rtl/dld_ifs.sv
// Valid/ready channel interfaces for the decimal divider: input digits,
// result words and divisor writes. Depends on dld_pkg for field widths.
interface dld_in_if;
  logic                        valid;
  logic                        ready;
  logic [dld_pkg::DIGIT_W-1:0] digit;
  logic                        last_integer_digit;

  modport source (output valid, output digit, output last_integer_digit, input ready);
  modport sink   (input valid, input digit, input last_integer_digit, output ready);
endinterface

interface dld_out_if;
  logic                        valid;
  logic                        ready;
  logic [dld_pkg::DIGIT_W-1:0] quotient_digit;
  logic                        is_fraction;
  logic                        run_end;
  logic [dld_pkg::REM_W-1:0]   final_remainder;
  logic                        divide_error;

  modport source (output valid, output quotient_digit, output is_fraction,
                  output run_end, output final_remainder, output divide_error,
                  input ready);
  modport sink   (input valid, input quotient_digit, input is_fraction,
                  input run_end, input final_remainder, input divide_error,
                  output ready);
endinterface

interface dld_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [dld_pkg::CFG_W-1:0] divisor;

  modport source (output valid, output divisor, input ready);
  modport sink   (input valid, input divisor, output ready);
endinterface

FILE: hw/rtl/dld_datapath.sv
// Datapath of the decimal divider: divisor, running remainder, the
// restoring divide step and the output word register. Uses dld_pkg.
module dld_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dld_pkg::dld_cmd_t           cmd,
  output dld_pkg::dld_sts_t           sts,
  input  logic [dld_pkg::DIGIT_W-1:0] in_digit,
  input  logic                        in_last,
  input  logic                        cfg_we,
  input  logic [dld_pkg::CFG_W-1:0]   cfg_divisor,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [dld_pkg::DIGIT_W-1:0] out_quotient_digit,
  output logic                        out_is_fraction,
  output logic                        out_run_end,
  output logic [dld_pkg::REM_W-1:0]   out_final_remainder,
  output logic                        out_divide_error
);
  import dld_pkg::*;

  logic [DIVISOR_BITS-1:0] divisor_r;
  logic [DIVISOR_BITS-1:0] rem_r;
  logic [FRAC_CNT_W-1:0]   fcnt_r;
  logic [PROD_W-1:0]       t_r;
  logic [QSTEPS-1:0]       q_r;
  logic                    last_r;
  logic                    frac_r;
  logic                    err_r;
  logic                    out_valid_r;
  logic [DIGIT_W-1:0]      out_qd_r;
  logic                    out_frac_r;
  logic                    out_end_r;
  logic [REM_W-1:0]        out_rem_r;
  logic                    out_err_r;

  logic [DIGIT_W-1:0]      digit_c;
  logic [DIVISOR_BITS-1:0] rem_cur;
  logic [DIVISOR_BITS-1:0] x10_src;
  logic [PROD_W-1:0]       x10;
  logic [PROD_W-1:0]       t_load;
  logic [PROD_W-1:0]       div_sh;
  logic [PROD_W-1:0]       diff;
  logic                    ge;
  logic                    rem_zero;
  logic                    fcnt_full;
  logic                    run_end;

  // Digits above nine count as nine.
  assign digit_c = (in_digit > DIGIT_MAX) ? DIGIT_MAX : in_digit;

  // After the last step the partial dividend holds the new remainder.
  assign rem_cur = t_r[DIVISOR_BITS-1:0];

  // Remainder times ten, from the stored remainder on a new digit or from
  // the fresh remainder when the fraction tail goes on.
  assign x10_src = cmd.emit ? rem_cur : rem_r;
  assign x10     = (PROD_W'(x10_src) << 3) + (PROD_W'(x10_src) << 1);
  assign t_load  = cmd.emit ? x10 : (x10 + PROD_W'(digit_c));

  // One restoring step against the divisor shifted to the current bit.
  assign div_sh = PROD_W'(divisor_r) << cmd.step_idx;
  assign ge     = (t_r >= div_sh);
  assign diff   = t_r - div_sh;

  // End of run and continuation of the fraction tail.
  assign rem_zero  = (t_r == '0);
  assign fcnt_full = (fcnt_r >= FRAC_CNT_W'(MAX_FRACTION_DIGITS));
  always_comb begin
    if (err_r) begin
      run_end = last_r;
    end else if (frac_r) begin
      run_end = rem_zero || fcnt_full;
    end else begin
      run_end = last_r && (rem_zero || NO_FRACTION);
    end
  end

  assign sts.div_zero = (divisor_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.cont     = !err_r && last_r && !run_end;

  // Divisor and running state; a divisor write starts a fresh division.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r <= DIVISOR_BITS'(1);
      rem_r     <= '0;
      fcnt_r    <= '0;
    end else if (cfg_we) begin
      divisor_r <= DIVISOR_BITS'(cfg_divisor);
      rem_r     <= '0;
      fcnt_r    <= '0;
    end else if (cmd.emit) begin
      if (run_end || err_r) begin
        rem_r <= '0;
      end else begin
        rem_r <= rem_cur;
      end
      if (sts.cont) begin
        fcnt_r <= frac_r ? (fcnt_r + FRAC_CNT_W'(1)) : FRAC_CNT_W'(1);
      end else if (run_end || !frac_r) begin
        fcnt_r <= '0;
      end
    end
  end

  // Working registers of the digit in progress.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r    <= t_load;
      q_r    <= '0;
      last_r <= in_last;
      frac_r <= 1'b0;
      err_r  <= sts.div_zero;
    end else if (cmd.step) begin
      t_r <= ge ? diff : t_r;
      q_r <= {q_r[QSTEPS-2:0], ge};
    end else if (cmd.emit && sts.cont) begin
      t_r    <= t_load;
      q_r    <= '0;
      frac_r <= 1'b1;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_qd_r   <= err_r ? '0 : DIGIT_W'(q_r);
      out_frac_r <= frac_r;
      out_end_r  <= run_end;
      out_rem_r  <= (run_end && !err_r) ? REM_W'(rem_cur) : '0;
      out_err_r  <= err_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_quotient_digit  = out_qd_r;
  assign out_is_fraction     = out_frac_r;
  assign out_run_end         = out_end_r;
  assign out_final_remainder = out_rem_r;
  assign out_divide_error    = out_err_r;

endmodule

FILE: hw/rtl/dld_ctrl.sv
// Controller of the decimal divider: sequences load, four divide steps
// (none on a zero divisor) and the result hand-off for each digit. Uses dld_pkg.
module dld_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              cfg_ready,
  input  dld_pkg::dld_sts_t sts,
  output dld_pkg::dld_cmd_t cmd
);
  import dld_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state_r;
  logic [1:0]        state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd.load     = 1'b0;
    cmd.step     = 1'b0;
    cmd.step_idx = step_r;
    cmd.emit     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          step_nxt = STEP_W'(QSTEPS - 1);
          state_nxt = sts.div_zero ? ST_EMIT : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.cont) begin
            step_nxt  = STEP_W'(QSTEPS - 1);
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // A digit word and a divisor write never land in the same cycle.
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE) && !in_valid;

endmodule

FILE: hw/rtl/decimal_long_division_by_small_int.sv
// Decimal long division of a digit stream by a configured small integer.
// Each accepted digit is loaded, passes four divide steps (none on a zero divisor)
// and is handed to the result register; fraction words repeat the steps and hand-off.
// A new digit is taken only after the previous one and its fraction tail are handed off.
// Reset (rst_n low, synchronous): divisor 1, remainder and count cleared.
// Depends on dld_pkg, dld_ifs, dld_ctrl and dld_datapath.
module decimal_long_division_by_small_int (
  input logic      clk,
  input logic      rst_n,
  dld_in_if.sink   in_ch,
  dld_out_if.source out_ch,
  dld_cfg_if.sink  cfg_ch
);
  import dld_pkg::*;

  dld_cmd_t cmd;
  dld_sts_t sts;
  logic     in_ready;
  logic     cfg_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = cfg_ready;

  // Sequencing of each digit.
  dld_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and result register.
  dld_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_digit            (in_ch.digit),
    .in_last             (in_ch.last_integer_digit),
    .cfg_we              (cfg_ch.valid && cfg_ready),
    .cfg_divisor         (cfg_ch.divisor),
    .out_ready           (out_ch.ready),
    .out_valid           (out_ch.valid),
    .out_quotient_digit  (out_ch.quotient_digit),
    .out_is_fraction     (out_ch.is_fraction),
    .out_run_end         (out_ch.run_end),
    .out_final_remainder (out_ch.final_remainder),
    .out_divide_error    (out_ch.divide_error)
  );

endmodule

FILE: hw/rtl/dld_checker.sv
// Port-level checker for the decimal divider, bound to the top level.
// Depends on dld_pkg and the assertion macro header.
`include "decimal_long_division_by_small_int_assert.svh"

module dld_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dld_pkg::DIGIT_W-1:0] quotient_digit,
  input logic                        is_fraction,
  input logic                        run_end,
  input logic [dld_pkg::REM_W-1:0]   final_remainder,
  input logic                        divide_error
);
  import dld_pkg::*;

  logic err_fields_clear;

  // A stalled result word stays offered.
  `DLD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // An error word carries no digit, no fraction mark and no remainder.
  assign err_fields_clear = (quotient_digit == '0) && !is_fraction && (final_remainder == '0);
  `DLD_ASSERT_IMPL(a_err_word, clk, rst_n, out_valid && divide_error, err_fields_clear)

  // The remainder is only reported on the last word of a run.
  `DLD_ASSERT_IMPL(a_rem_on_end, clk, rst_n, out_valid && !run_end, final_remainder == '0)

  // Quotient digits are decimal.
  `DLD_ASSERT_IMPL(a_digit_range, clk, rst_n, out_valid, quotient_digit <= DIGIT_MAX)

endmodule

bind decimal_long_division_by_small_int dld_checker u_dld_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .quotient_digit  (out_ch.quotient_digit),
  .is_fraction     (out_ch.is_fraction),
  .run_end         (out_ch.run_end),
  .final_remainder (out_ch.final_remainder),
  .divide_error    (out_ch.divide_error)
);

FILE: sim/tb_decimal_long_division_by_small_int.sv
// Testbench for the decimal long divider: streams dividend digits in, checks every
// quotient word against a local long-division predictor across several divisors.
// Depends on dld_pkg, dld_ifs and the decimal_long_division_by_small_int RTL.
module tb_decimal_long_division_by_small_int;
  timeunit 1ns;
  timeprecision 1ps;

  import dld_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER_DIGITS = 60;
  localparam int SETTLE_CYCLES = 10;
  localparam int REPORT_MAX = 10;
  localparam int PHASE_ITEMS = 16;

  // One dividend digit waiting to be sent.
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } digit_item_t;

  // One quotient word as the result channel carries it.
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               frac;
    logic               run_end;
    logic [REM_W-1:0]   rem;
    logic               err;
  } quot_word_t;

  logic clk = 1'b0;
  logic rst_n;

  dld_in_if  in_if ();
  dld_out_if out_if ();
  dld_cfg_if cfg_if ();

  decimal_long_division_by_small_int dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Predictor state: divisor register and the running division.
  logic [DIVISOR_BITS-1:0] divisor_reg;
  logic [DIVISOR_BITS-1:0] rem_acc;
  int                      frac_count;

  digit_item_t digits_pending_q[$];
  quot_word_t  quot_expected_q[$];

  int  digits_queued = 0;
  int  digits_taken = 0;
  int  mismatches = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  no_gap = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void push_word(input logic [DIGIT_W-1:0] q, input logic frac,
                                    input logic fin, input logic [REM_W-1:0] rem,
                                    input logic err);
    quot_word_t w;
    w = '{digit: q, frac: frac, run_end: fin, rem: fin ? rem : '0, err: err};
    quot_expected_q.push_back(w);
  endfunction

  // Long division of one accepted digit; a last integer digit also runs the
  // fraction tail until the remainder clears or the fraction limit is hit.
  function automatic void predict_quotient(input logic [DIGIT_W-1:0] d_in, input logic last);
    logic [31:0]        d;
    logic [31:0]        t;
    logic [DIGIT_W-1:0] q;
    logic               fin;
    d = (d_in > DIGIT_MAX) ? 32'd9 : 32'(d_in);
    if (divisor_reg == '0) begin
      push_word('0, 1'b0, last, '0, 1'b1);
      if (last) begin
        rem_acc = '0;
        frac_count = 0;
      end
      return;
    end
    t = 32'(rem_acc) * 32'd10 + d;
    q = DIGIT_W'(t / 32'(divisor_reg));
    rem_acc = DIVISOR_BITS'(t % 32'(divisor_reg));
    if (!last) begin
      push_word(q, 1'b0, 1'b0, '0, 1'b0);
      return;
    end
    frac_count = 0;
    // An exact integer part, or no fraction allowed, ends the run here.
    if (rem_acc == '0 || MAX_FRACTION_DIGITS == 0) begin
      push_word(q, 1'b0, 1'b1, REM_W'(rem_acc), 1'b0);
      rem_acc = '0;
      return;
    end
    push_word(q, 1'b0, 1'b0, '0, 1'b0);
    do begin
      t = 32'(rem_acc) * 32'd10;
      q = DIGIT_W'(t / 32'(divisor_reg));
      rem_acc = DIVISOR_BITS'(t % 32'(divisor_reg));
      frac_count++;
      fin = (rem_acc == '0) || (frac_count >= MAX_FRACTION_DIGITS);
      push_word(q, 1'b1, fin, REM_W'(rem_acc), 1'b0);
    end while (!fin);
    rem_acc = '0;
    frac_count = 0;
  endfunction

  function automatic string word_str(input quot_word_t w);
    return $sformatf("digit=%0d frac=%0b end=%0b rem=%0d err=%0b",
                     w.digit, w.frac, w.run_end, w.rem, w.err);
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // Mostly legal digits, now and then one above nine.
  function automatic logic [DIGIT_W-1:0] rand_digit();
    if ($urandom_range(0, 99) < 8) return DIGIT_W'($urandom_range(10, 15));
    return DIGIT_W'($urandom_range(0, 9));
  endfunction

  task automatic queue_digit(input logic [DIGIT_W-1:0] d, input logic last);
    digit_item_t it;
    it = '{digit: d, last: last};
    digits_pending_q.push_back(it);
    digits_queued++;
  endtask

  // A whole division: n integer digits, the final one marked.
  task automatic queue_run(input int n);
    for (int i = 0; i < n; i++) queue_digit(rand_digit(), i == n - 1);
  endtask

  // Wait until every digit is taken and every word has come back.
  task automatic wait_idle();
    while (digits_taken != digits_queued || quot_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_divisor(input logic [CFG_W-1:0] v);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.divisor <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    divisor_reg = v[DIVISOR_BITS-1:0];
    rem_acc = '0;
    frac_count = 0;
  endtask

  // Random divisions under one divisor; sometimes a run is left unfinished
  // so the next divisor write has to clear it.
  task automatic random_phase(input logic [CFG_W-1:0] v, input int n_items);
    int sent;
    int len;
    sent = 0;
    write_divisor(v);
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
      queue_run(len);
      sent += len;
    end
    if ($urandom_range(0, 99) < 30) begin
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) queue_digit(rand_digit(), 1'b0);
    end
  endtask

  // Driver: presents pending digits and predicts each one that is accepted.
  always @(posedge clk) begin : driver
    digit_item_t it;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_quotient(in_if.digit, in_if.last_integer_digit);
        digits_taken <= digits_taken + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (digits_pending_q.size() > 0 && (no_gap || $urandom_range(0, 99) >= 36)) begin
          it = digits_pending_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.digit <= it.digit;
          in_if.last_integer_digit <= it.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off while digits keep coming.
  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && digits_taken >= HOLD_AFTER_DIGITS) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= no_gap || ($urandom_range(0, 99) >= 36);
    end
  end

  // Monitor: each accepted word against the oldest expected word.
  always @(posedge clk) begin : monitor
    quot_word_t exp_w;
    quot_word_t act_w;
    if (rst_n && out_if.valid && out_if.ready) begin
      act_w = '{digit: out_if.quotient_digit, frac: out_if.is_fraction,
                run_end: out_if.run_end, rem: out_if.final_remainder,
                err: out_if.divide_error};
      if (quot_expected_q.size() == 0) begin
        note_mismatch($sformatf("unexpected word: %s", word_str(act_w)));
      end else begin
        exp_w = quot_expected_q.pop_front();
        if (act_w.digit !== exp_w.digit || act_w.frac !== exp_w.frac ||
            act_w.run_end !== exp_w.run_end || act_w.rem !== exp_w.rem ||
            act_w.err !== exp_w.err) begin
          note_mismatch($sformatf("expected %s, got %s", word_str(exp_w), word_str(act_w)));
        end
      end
    end
  end

  // Watchdog: ends the run after too long without any handshake.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.digit = '0;
    in_if.last_integer_digit = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.divisor = '0;
    divisor_reg = DIVISOR_BITS'(1);
    rem_acc = '0;
    frac_count = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset divisor of one: digits pass straight through, digits above nine
    // act as nine, and every integer part is exact.
    queue_digit(4'd0, 1'b0);
    queue_digit(4'd9, 1'b0);
    queue_digit(4'd15, 1'b0);
    queue_digit(4'd4, 1'b1);
    queue_digit(4'd9, 1'b1);

    // Sevenths repeat forever, so the fraction limit ends these runs.
    write_divisor(16'd7);
    queue_digit(4'd1, 1'b1);
    queue_digit(4'd2, 1'b0);
    queue_digit(4'd15, 1'b1);

    // A divisor write in the middle of a run starts a fresh division.
    write_divisor(16'd4);
    queue_digit(4'd3, 1'b0);
    queue_digit(4'd4, 1'b0);
    write_divisor(16'd8);
    queue_digit(4'd2, 1'b0);
    queue_digit(4'd0, 1'b1);
    queue_digit(4'd1, 1'b1);

    // Zero divisor: error words only.
    write_divisor(16'd0);
    queue_digit(4'd5, 1'b0);
    queue_digit(4'd3, 1'b1);
    queue_digit(4'd15, 1'b1);

    // Largest divisor: a long fraction tail, then a zero dividend.
    write_divisor(16'hFFFF);
    for (int i = 0; i < 4; i++) queue_digit(4'd9, 1'b0);
    queue_digit(4'd9, 1'b1);
    queue_digit(4'd0, 1'b1);

    // Random divisions across a spread of divisors.
    random_phase(16'd3, PHASE_ITEMS);
    random_phase(16'd7, PHASE_ITEMS);
    random_phase(16'd0, PHASE_ITEMS);
    random_phase(16'hFFFF, PHASE_ITEMS);
    // One stretch with no idling on either side.
    wait_idle();
    no_gap = 1'b1;
    random_phase(16'd10, PHASE_ITEMS);
    wait_idle();
    no_gap = 1'b0;
    random_phase(16'd13, PHASE_ITEMS);
    random_phase(16'd97, PHASE_ITEMS);
    random_phase(16'd1, PHASE_ITEMS);
    random_phase(CFG_W'($urandom_range(2, 40)), PHASE_ITEMS);
    random_phase(CFG_W'($urandom_range(1, 65535)), PHASE_ITEMS);

    wait_idle();
    if (mismatches == 0 && quot_expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
